>>> hdl/sgi_pkg.sv
// Shared widths, types and codes for the segment intersection block.
package sgi_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int MAG_BITS   = CROSS_BITS - 1;
   localparam int TERM_BITS  = CROSS_BITS + DIFF_BITS;
   localparam int SUM_BITS   = TERM_BITS + 1;
   localparam int NMAG_BITS  = TERM_BITS;
   localparam int REM_BITS   = NMAG_BITS - COORD_BITS;
   localparam int THR_BITS   = 35;

   typedef enum logic [1:0] {
      OUT_CROSSING = 2'd0,
      OUT_PARALLEL = 2'd1,
      OUT_OUTSIDE  = 2'd2
   } outcome_type;

   // one classified transaction handed from the front end to the back end
   typedef struct packed {
      outcome_type                  outcome;
      logic signed [CROSS_BITS-1:0] den;
      logic signed [TERM_BITS-1:0]  px_base;
      logic signed [TERM_BITS-1:0]  px_step;
      logic signed [TERM_BITS-1:0]  py_base;
      logic signed [TERM_BITS-1:0]  py_step;
   } entry_type;

endpackage

>>> hdl/sgi_front.sv
// Front end: differences, cross products, classification and numerator terms.
module sgi_front
   import sgi_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] a_start_x,
   input  logic signed [COORD_BITS-1:0] a_start_y,
   input  logic signed [COORD_BITS-1:0] a_end_x,
   input  logic signed [COORD_BITS-1:0] a_end_y,
   input  logic signed [COORD_BITS-1:0] b_start_x,
   input  logic signed [COORD_BITS-1:0] b_start_y,
   input  logic signed [COORD_BITS-1:0] b_end_x,
   input  logic signed [COORD_BITS-1:0] b_end_y,
   input  logic        [THR_BITS-1:0]   threshold,
   output logic                         out_valid,
   output entry_type                    out_entry
);

   // stage 1: differences
   logic                        v1_ff;
   logic signed [DIFF_BITS-1:0] d12x_ff, d12y_ff, d34x_ff, d34y_ff, d13x_ff, d13y_ff;
   logic signed [DIFF_BITS-1:0] dxa_ff, dya_ff;
   logic signed [COORD_BITS-1:0] x1_s1_ff, y1_s1_ff;

   // stage 2: products
   logic                        v2_ff;
   logic signed [PROD_BITS-1:0] pd1_ff, pd2_ff, pt1_ff, pt2_ff, pu1_ff, pu2_ff;
   logic signed [DIFF_BITS-1:0] dxa2_ff, dya2_ff;
   logic signed [COORD_BITS-1:0] x1_s2_ff, y1_s2_ff;

   // stage 3: cross products
   logic                         v3_ff;
   logic signed [CROSS_BITS-1:0] den_ff, numt_ff, numu_ff;
   logic signed [DIFF_BITS-1:0]  dxa3_ff, dya3_ff;
   logic signed [COORD_BITS-1:0] x1_s3_ff, y1_s3_ff;

   // stage 4: classification and terms
   logic      v4_ff;
   entry_type entry_ff, entry_in;

   logic [CROSS_BITS-1:0] abs_den, abs_t, abs_u;
   logic                  t_ok, u_ok, par;

   function automatic logic signed [DIFF_BITS-1:0] sub_c(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      sub_c = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
   endfunction

   always_comb begin
      abs_den = den_ff[CROSS_BITS-1]  ? CROSS_BITS'(-den_ff)  : CROSS_BITS'(den_ff);
      abs_t   = numt_ff[CROSS_BITS-1] ? CROSS_BITS'(-numt_ff) : CROSS_BITS'(numt_ff);
      abs_u   = numu_ff[CROSS_BITS-1] ? CROSS_BITS'(-numu_ff) : CROSS_BITS'(numu_ff);
      par  = (den_ff == '0) || (abs_den < threshold);
      t_ok = (numt_ff == '0) ||
             ((numt_ff[CROSS_BITS-1] == den_ff[CROSS_BITS-1]) && (abs_t <= abs_den));
      u_ok = (numu_ff == '0) ||
             ((numu_ff[CROSS_BITS-1] == den_ff[CROSS_BITS-1]) && (abs_u <= abs_den));
      if (par) begin
         entry_in.outcome = OUT_PARALLEL;
      end else if (!t_ok || !u_ok) begin
         entry_in.outcome = OUT_OUTSIDE;
      end else begin
         entry_in.outcome = OUT_CROSSING;
      end
      entry_in.den     = den_ff;
      entry_in.px_base = TERM_BITS'(den_ff * x1_s3_ff);
      entry_in.px_step = TERM_BITS'(numt_ff * dxa3_ff);
      entry_in.py_base = TERM_BITS'(den_ff * y1_s3_ff);
      entry_in.py_step = TERM_BITS'(numt_ff * dya3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      d12x_ff  <= sub_c(a_start_x, a_end_x);
      d12y_ff  <= sub_c(a_start_y, a_end_y);
      d34x_ff  <= sub_c(b_start_x, b_end_x);
      d34y_ff  <= sub_c(b_start_y, b_end_y);
      d13x_ff  <= sub_c(a_start_x, b_start_x);
      d13y_ff  <= sub_c(a_start_y, b_start_y);
      dxa_ff   <= sub_c(a_end_x, a_start_x);
      dya_ff   <= sub_c(a_end_y, a_start_y);
      x1_s1_ff <= a_start_x;
      y1_s1_ff <= a_start_y;

      pd1_ff   <= d12x_ff * d34y_ff;
      pd2_ff   <= d12y_ff * d34x_ff;
      pt1_ff   <= d13x_ff * d34y_ff;
      pt2_ff   <= d13y_ff * d34x_ff;
      pu1_ff   <= d12y_ff * d13x_ff;
      pu2_ff   <= d12x_ff * d13y_ff;
      dxa2_ff  <= dxa_ff;
      dya2_ff  <= dya_ff;
      x1_s2_ff <= x1_s1_ff;
      y1_s2_ff <= y1_s1_ff;

      den_ff   <= CROSS_BITS'(pd1_ff) - CROSS_BITS'(pd2_ff);
      numt_ff  <= CROSS_BITS'(pt1_ff) - CROSS_BITS'(pt2_ff);
      numu_ff  <= CROSS_BITS'(pu1_ff) - CROSS_BITS'(pu2_ff);
      dxa3_ff  <= dxa2_ff;
      dya3_ff  <= dya2_ff;
      x1_s3_ff <= x1_s2_ff;
      y1_s3_ff <= y1_s2_ff;

      entry_ff <= entry_in;
   end

   assign out_valid = v4_ff;
   assign out_entry = entry_ff;

endmodule

>>> hdl/sgi_fifo.sv
// Two-entry queue between front end and back end.
module sgi_fifo
   import sgi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   entry_type  mem [0:1];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

>>> hdl/sgi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module sgi_div
   import sgi_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [NMAG_BITS-1:0]    in_mag,
   input  logic [MAG_BITS-1:0]     in_div,
   input  logic                    in_neg,
   output logic                    out_valid,
   output logic [COORD_BITS-1:0]   out_quot,
   output logic                    out_neg
);

   logic                  v_ff   [0:COORD_BITS-1];
   logic [REM_BITS-1:0]   rem_ff [0:COORD_BITS-1];
   logic [COORD_BITS-1:0] lo_ff  [0:COORD_BITS-1];
   logic [COORD_BITS-1:0] q_ff   [0:COORD_BITS-1];
   logic [MAG_BITS-1:0]   d_ff   [0:COORD_BITS-1];
   logic                  neg_ff [0:COORD_BITS-1];

   for (genvar k = 0; k < COORD_BITS; k++) begin : g_stage
      logic                  src_v, src_neg, ge;
      logic [REM_BITS-1:0]   src_rem;
      logic [COORD_BITS-1:0] src_lo, src_q;
      logic [MAG_BITS-1:0]   src_d;
      logic [REM_BITS:0]     trial, diff;

      if (k == 0) begin : g_first
         assign src_v   = in_valid;
         assign src_rem = in_mag[NMAG_BITS-1:COORD_BITS];
         assign src_lo  = in_mag[COORD_BITS-1:0];
         assign src_q   = '0;
         assign src_d   = in_div;
         assign src_neg = in_neg;
      end else begin : g_next
         assign src_v   = v_ff[k-1];
         assign src_rem = rem_ff[k-1];
         assign src_lo  = lo_ff[k-1];
         assign src_q   = q_ff[k-1];
         assign src_d   = d_ff[k-1];
         assign src_neg = neg_ff[k-1];
      end

      assign trial = {src_rem, src_lo[COORD_BITS-1]};
      assign ge    = trial >= (REM_BITS+1)'(src_d);
      assign diff  = trial - (REM_BITS+1)'(src_d);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= src_v;
         end
         rem_ff[k] <= ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
         lo_ff[k]  <= {src_lo[COORD_BITS-2:0], 1'b0};
         q_ff[k]   <= {src_q[COORD_BITS-2:0], ge};
         d_ff[k]   <= src_d;
         neg_ff[k] <= src_neg;
      end
   end

   assign out_valid = v_ff[COORD_BITS-1];
   assign out_quot  = q_ff[COORD_BITS-1];
   assign out_neg   = neg_ff[COORD_BITS-1];

endmodule

>>> hdl/sgi_back.sv
// Back end: crossing numerators, two dividers and the result register.
module sgi_back
   import sgi_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  entry_type                    in_entry,
   output logic                         out_valid,
   output logic [1:0]                   out_outcome,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y
);

   logic signed [SUM_BITS-1:0] nx, ny;
   logic                       b0_v_ff;
   logic [NMAG_BITS-1:0]       magx_ff, magy_ff;
   logic [MAG_BITS-1:0]        dmag_ff;
   logic                       negx_ff, negy_ff;
   outcome_type                oc0_ff;
   outcome_type                oc_ff [0:COORD_BITS-1];

   logic                  qx_v, qy_v, qx_neg, qy_neg;
   logic [COORD_BITS-1:0] qx, qy;

   logic                  rv_ff;
   outcome_type           roc_ff;
   logic [COORD_BITS-1:0] rx_ff, ry_ff;

   assign nx = SUM_BITS'(in_entry.px_base) + SUM_BITS'(in_entry.px_step);
   assign ny = SUM_BITS'(in_entry.py_base) + SUM_BITS'(in_entry.py_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_v_ff <= 1'b0;
      end else begin
         b0_v_ff <= in_valid;
      end
      magx_ff <= nx[SUM_BITS-1] ? NMAG_BITS'(-nx) : NMAG_BITS'(nx);
      magy_ff <= ny[SUM_BITS-1] ? NMAG_BITS'(-ny) : NMAG_BITS'(ny);
      dmag_ff <= in_entry.den[CROSS_BITS-1] ? MAG_BITS'(-in_entry.den)
                                            : MAG_BITS'(in_entry.den);
      negx_ff <= nx[SUM_BITS-1] ^ in_entry.den[CROSS_BITS-1];
      negy_ff <= ny[SUM_BITS-1] ^ in_entry.den[CROSS_BITS-1];
      oc0_ff  <= in_entry.outcome;
   end

   sgi_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b0_v_ff),
      .in_mag    (magx_ff),
      .in_div    (dmag_ff),
      .in_neg    (negx_ff),
      .out_valid (qx_v),
      .out_quot  (qx),
      .out_neg   (qx_neg)
   );

   sgi_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b0_v_ff),
      .in_mag    (magy_ff),
      .in_div    (dmag_ff),
      .in_neg    (negy_ff),
      .out_valid (qy_v),
      .out_quot  (qy),
      .out_neg   (qy_neg)
   );

   // outcome travels alongside the divider stages
   always_ff @(posedge clock) begin
      oc_ff[0] <= oc0_ff;
      for (int k = 1; k < COORD_BITS; k++) begin
         oc_ff[k] <= oc_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= qx_v && qy_v;
      end
      roc_ff <= oc_ff[COORD_BITS-1];
      if (oc_ff[COORD_BITS-1] == OUT_CROSSING) begin
         rx_ff <= qx_neg ? COORD_BITS'(-qx) : qx;
         ry_ff <= qy_neg ? COORD_BITS'(-qy) : qy;
      end else begin
         rx_ff <= '0;
         ry_ff <= '0;
      end
   end

   assign out_valid   = rv_ff;
   assign out_outcome = roc_ff;
   assign out_x       = $signed(rx_ff);
   assign out_y       = $signed(ry_ff);

endmodule

>>> hdl/segment_intersection.sv
// Top level of the 2D segment intersection block.
//
// Usage:
//   Drive the eight endpoint coordinates of segments A and B on req_* and
//   raise start; the transaction is taken at a clock edge where start is
//   high and busy is low. A new transaction may follow in every cycle.
//   Each transaction yields exactly one result on rsp_*, marked by a
//   one-cycle rsp_valid pulse; on its way the transaction passes, in
//   order, 4 front-end stages, the queue, one back-end setup stage, 16
//   divider stages and the result register. The receiver cannot stall;
//   results are never held.
//   Throughput is one transaction per clock, set by the fully pipelined
//   multipliers in the front end and the 16-stage dividers in the back end.
//   rsp_outcome: crossing found, parallel, or crossing outside a segment;
//   cross point fields are zero unless a crossing was found.
//   csr_wr_en/csr_wr_data write parallel_threshold (|den| below it counts
//   as parallel); write it only while no transaction is in flight.
//   Reset (synchronous, active high) empties the pipeline and sets the
//   threshold to 1, so only exactly parallel segments report parallel.
module segment_intersection
   import sgi_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_a_start_x,
   input  logic signed [COORD_BITS-1:0] req_a_start_y,
   input  logic signed [COORD_BITS-1:0] req_a_end_x,
   input  logic signed [COORD_BITS-1:0] req_a_end_y,
   input  logic signed [COORD_BITS-1:0] req_b_start_x,
   input  logic signed [COORD_BITS-1:0] req_b_start_y,
   input  logic signed [COORD_BITS-1:0] req_b_end_x,
   input  logic signed [COORD_BITS-1:0] req_b_end_y,
   input  logic                         csr_wr_en,
   input  logic [THR_BITS-1:0]          csr_wr_data,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_outcome,
   output logic signed [COORD_BITS-1:0] rsp_cross_x,
   output logic signed [COORD_BITS-1:0] rsp_cross_y
);

   logic [THR_BITS-1:0] thr_ff;
   logic                accept;
   logic                f_valid, q_full, q_nempty;
   entry_type           f_entry, q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_BITS'(1);
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // the back end drains the queue every cycle, so it never fills in
   // practice; busy follows a full queue
   assign busy   = q_full;
   assign accept = start && !busy;

   sgi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .a_start_x (req_a_start_x),
      .a_start_y (req_a_start_y),
      .a_end_x   (req_a_end_x),
      .a_end_y   (req_a_end_y),
      .b_start_x (req_b_start_x),
      .b_start_y (req_b_start_y),
      .b_end_x   (req_b_end_x),
      .b_end_y   (req_b_end_y),
      .threshold (thr_ff),
      .out_valid (f_valid),
      .out_entry (f_entry)
   );

   sgi_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_entry (f_entry),
      .pop        (q_nempty),
      .full       (q_full),
      .not_empty  (q_nempty),
      .head       (q_head)
   );

   sgi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_nempty),
      .in_entry    (q_head),
      .out_valid   (rsp_valid),
      .out_outcome (rsp_outcome),
      .out_x       (rsp_cross_x),
      .out_y       (rsp_cross_y)
   );

endmodule
